### rtl/i2cmws_pkg.sv
// Shared types, status codes and the command frame table of the I2C
// write/read sequencer. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package i2cmws_pkg;

	// default frame lengths
	localparam int SEND_LEN_DEF = 6;
	localparam int RECV_LEN_DEF = 21;

	localparam int ROW_LEN    = 6;
	localparam int KEY_COLUMN = 3;

	// controller status codes
	localparam logic [7:0] ST_START      = 8'h08;
	localparam logic [7:0] ST_RESTART    = 8'h10;
	localparam logic [7:0] ST_SLA_W_ACK  = 8'h18;
	localparam logic [7:0] ST_SLA_W_NACK = 8'h20;
	localparam logic [7:0] ST_DATA_ACK   = 8'h28;
	localparam logic [7:0] ST_DATA_NACK  = 8'h30;
	localparam logic [7:0] ST_SLA_R_ACK  = 8'h40;
	localparam logic [7:0] ST_RX_ACK     = 8'h50;
	localparam logic [7:0] ST_RX_NACK    = 8'h58;

	// command codes
	localparam logic CMD_BEGIN = 1'b0;
	localparam logic CMD_EVENT = 1'b1;

	// config register indexes
	localparam logic [1:0] CFG_COMMAND_INDEX  = 2'd0;
	localparam logic [1:0] CFG_TARGET_ADDRESS = 2'd1;
	localparam logic [1:0] CFG_READ_MODE      = 2'd2;

	// response positions that carry scrambled bytes
	localparam logic [4:0] SCRAMBLE_FIRST = 5'd2;
	localparam logic [4:0] SCRAMBLE_LAST  = 5'd19;

	localparam logic [7:0] FRAMES [0:7][0:ROW_LEN-1] = '{
		'{8'hAA, 8'h04, 8'h01, 8'hE6, 8'h01, 8'hE2},
		'{8'hAA, 8'h04, 8'h02, 8'hE6, 8'h01, 8'hE1},
		'{8'hAA, 8'h04, 8'h03, 8'hE6, 8'h01, 8'hE0},
		'{8'hAA, 8'h04, 8'h04, 8'hE6, 8'h01, 8'hE7},
		'{8'hAA, 8'h04, 8'h05, 8'hE6, 8'h01, 8'hE6},
		'{8'hAA, 8'h04, 8'h06, 8'hE6, 8'h01, 8'hE5},
		'{8'hAA, 8'h04, 8'h07, 8'hE6, 8'h01, 8'hE4},
		'{8'hAA, 8'h04, 8'h08, 8'hE0, 8'h01, 8'hED}
	};

	typedef struct packed {
		logic       command;
		logic [7:0] status_code;
		logic [7:0] bus_byte;
	} evt_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       tx_load;
		logic       ctl_start;
		logic       ctl_stop;
		logic       ctl_ack;
		logic [7:0] rx_data;
		logic       rx_valid;
		logic [4:0] rx_position;
		logic       transfer_done;
	} res_t;

	typedef struct packed {
		logic [2:0] command_index;
		logic [6:0] target_address;
		logic       read_mode;
	} cfg_t;

	typedef struct packed {
		logic [2:0] sent_count;
		logic [4:0] received_count;
		logic       done;
	} seq_state_t;

	// positions past the row read as zero
	function automatic logic [7:0] frame_byte(input logic [2:0] row, input logic [2:0] pos);
		logic [7:0] b;
		b = 8'h00;
		if (pos < 3'(ROW_LEN))
			b = FRAMES[row][pos];
		return b;
	endfunction

endpackage

`default_nettype wire

### rtl/i2cmws_decode.sv
// Status decoder: result item and next sequencer state from one event.
// Depends on i2cmws_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2cmws_decode #(
	parameter int SEND_LEN = i2cmws_pkg::SEND_LEN_DEF,
	parameter int RECV_LEN = i2cmws_pkg::RECV_LEN_DEF
) (
	input  wire i2cmws_pkg::evt_t       evt,
	input  wire i2cmws_pkg::cfg_t       cfg,
	input  wire i2cmws_pkg::seq_state_t cur,
	output i2cmws_pkg::seq_state_t      nxt,
	output i2cmws_pkg::res_t            res
);
	import i2cmws_pkg::*;

	localparam logic [2:0] SendLen = 3'(SEND_LEN);
	localparam logic [4:0] RecvLen = 5'(RECV_LEN);

	logic       store;
	logic [7:0] tx_next;
	logic [2:0] sent_inc;
	logic [7:0] rx_byte;

	assign tx_next  = frame_byte(cfg.command_index, cur.sent_count);
	assign sent_inc = (cur.sent_count != 3'd7) ? cur.sent_count + 3'd1 : cur.sent_count;

	always_comb begin
		nxt   = cur;
		res   = '0;
		store = 1'b0;
		if (evt.command == CMD_BEGIN) begin
			nxt           = '0;
			res.ctl_start = 1'b1;
		end else begin
			case (evt.status_code)
				ST_START: begin
					res.tx_byte = {cfg.target_address, 1'b0};
					res.tx_load = 1'b1;
				end
				ST_SLA_W_ACK: begin
					res.tx_byte    = tx_next;
					res.tx_load    = 1'b1;
					nxt.sent_count = sent_inc;
				end
				ST_SLA_W_NACK: begin
					res.ctl_stop = 1'b1;
					nxt.done     = 1'b1;
				end
				ST_DATA_ACK: begin
					if (cur.sent_count < SendLen) begin
						res.tx_byte    = tx_next;
						res.tx_load    = 1'b1;
						nxt.sent_count = sent_inc;
					end else if (cfg.read_mode) begin
						res.ctl_start = 1'b1;
					end else begin
						res.ctl_stop = 1'b1;
						nxt.done     = 1'b1;
					end
				end
				default: begin
					if (!cfg.read_mode) begin
						nxt.done = 1'b1;
					end else begin
						case (evt.status_code)
							ST_RESTART: begin
								res.tx_byte = {cfg.target_address, 1'b1};
								res.tx_load = 1'b1;
							end
							ST_SLA_R_ACK: res.ctl_ack = 1'b1;
							ST_RX_ACK: begin
								if (cur.received_count < RecvLen) begin
									store       = 1'b1;
									res.ctl_ack = 1'b1;
								end
							end
							ST_RX_NACK: begin
								store        = cur.received_count < RecvLen;
								res.ctl_stop = 1'b1;
								nxt.done     = 1'b1;
							end
							ST_DATA_NACK: begin
								res.ctl_stop       = 1'b1;
								nxt.done           = 1'b1;
								nxt.received_count = '0;
							end
							default: begin
								res.ctl_stop = 1'b1;
								nxt.done     = 1'b1;
							end
						endcase
					end
				end
			endcase
		end

		// descramble middle of the response for the low command rows
		rx_byte = evt.bus_byte;
		if (!cfg.command_index[2]
				&& (cur.received_count inside {[SCRAMBLE_FIRST:SCRAMBLE_LAST]}))
			rx_byte = evt.bus_byte ^ frame_byte(cfg.command_index, 3'(KEY_COLUMN));

		if (store) begin
			res.rx_position    = cur.received_count;
			res.rx_data        = rx_byte;
			res.rx_valid       = 1'b1;
			nxt.received_count = cur.received_count + 5'd1;
		end
		// final NACKed byte closes the response
		if (evt.command == CMD_EVENT && cfg.read_mode && evt.status_code == ST_RX_NACK)
			nxt.received_count = '0;

		res.transfer_done = nxt.done;
	end

endmodule

`default_nettype wire

### rtl/i2c_master_write_read_sequencer_unit.sv
// Top level of the I2C master write/read sequencer: event register, status
// decoder, sequencer state and result register. Depends on i2cmws_pkg and
// i2cmws_decode.
//
// Usage:
//   evt channel (evt_valid/evt_ready/evt) carries one controller event per
//   transfer: command 0 begins a transaction (clears counters, asks START),
//   command 1 reports a status code with the byte read from the data register.
//   res channel (res_valid/res_ready/res) returns exactly one result per event:
//   byte to load, START/STOP/ACK controls, stored response byte with its
//   position, and the done flag.
//   cfg port: cfg_we writes cfg_data into register cfg_index (0 command
//   index, 1 target address, 2 read mode) at the clock edge; index 3 is
//   ignored. Write only while no event is in flight.
// Timing:
//   An accepted event sits in the event register while the decoder works on
//   it; its result is registered once the result register is free or
//   draining. One event per cycle is sustained while res_ready stays high;
//   the decoder plus the count registers form the single loop.
// Stall: when res_ready is low the result holds, the event register keeps
//   one more event, and evt_ready drops only when both are full.
// Reset: counters and done flag clear, command index 0, address 0, read
//   mode 1, both channels empty.
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_write_read_sequencer_unit #(
	parameter int SEND_LEN = i2cmws_pkg::SEND_LEN_DEF,
	parameter int RECV_LEN = i2cmws_pkg::RECV_LEN_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  evt_valid,
	output logic                 evt_ready,
	input  wire i2cmws_pkg::evt_t evt,
	output logic                 res_valid,
	input  wire                  res_ready,
	output i2cmws_pkg::res_t     res,
	input  wire                  cfg_we,
	input  wire [1:0]            cfg_index,
	input  wire [6:0]            cfg_data
);
	import i2cmws_pkg::*;

	evt_t       evt_s1;
	logic       valid_s1;
	cfg_t       cfg_q;
	seq_state_t state_q;
	seq_state_t state_nxt;
	res_t       res_nxt;
	logic       advance;

	// event moves to the result register when the latter is free or draining
	assign advance   = valid_s1 && (!res_valid || res_ready);
	assign evt_ready = !valid_s1 || advance;

	i2cmws_decode #(
		.SEND_LEN(SEND_LEN),
		.RECV_LEN(RECV_LEN)
	) u_decode (
		.evt(evt_s1),
		.cfg(cfg_q),
		.cur(state_q),
		.nxt(state_nxt),
		.res(res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			res_valid <= 1'b0;
			state_q   <= '0;
		end else begin
			if (evt_ready)
				valid_s1 <= evt_valid;
			if (advance) begin
				res_valid <= 1'b1;
				state_q   <= state_nxt;
			end else if (res_ready) begin
				res_valid <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (evt_ready && evt_valid)
			evt_s1 <= evt;
		if (advance)
			res <= res_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.command_index  <= 3'd0;
			cfg_q.target_address <= 7'd0;
			cfg_q.read_mode      <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_COMMAND_INDEX:  cfg_q.command_index  <= cfg_data[2:0];
				CFG_TARGET_ADDRESS: cfg_q.target_address <= cfg_data;
				CFG_READ_MODE:      cfg_q.read_mode      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// back-pressure only when both registers hold an item and output stalls
	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!evt_ready |-> (valid_s1 && res_valid && !res_ready))
		else $error("event channel stalled without a full pipeline");

	// receive count never runs past the buffer
	a_rx_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.received_count <= 5'(RECV_LEN))
		else $error("received count past buffer length");

	// a stored byte lies within the buffer
	a_rx_position_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.rx_valid) |-> (res.rx_position < 5'(RECV_LEN)))
		else $error("response byte position outside buffer");

	// a begin clears done in the result it produces
	a_begin_clears_done: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && evt_s1.command == CMD_BEGIN) |=> (res.ctl_start && !res.transfer_done))
		else $error("begin did not clear done");

	// unused fields stay zero
	a_idle_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ((res.tx_load || res.tx_byte == 8'h00)
			&& (res.rx_valid || (res.rx_data == 8'h00 && res.rx_position == 5'd0))))
		else $error("inactive result field not zero");

endmodule

`default_nettype wire

### tb/i2cmws_tb_pkg.sv
// Scoreboard for the I2C write/read sequencer bench: a cycle-free predictor of
// the status decoder and the queue of results it expects. Depends on i2cmws_pkg.
`timescale 1ns / 1ps

package i2cmws_tb_pkg;

	import i2cmws_pkg::*;

	class seq_scoreboard;

		// shadow registers, reset values as in the block
		logic [2:0] cmd_idx;
		logic [6:0] tgt_addr;
		logic       rd_mode;

		// sequencer state
		logic [2:0] n_sent;
		logic [4:0] n_recv;
		logic       done;

		res_t exp_q[$];
		int   n_bad;

		function new();
			cmd_idx  = 3'd0;
			tgt_addr = 7'd0;
			rd_mode  = 1'b1;
			n_sent   = 3'd0;
			n_recv   = 5'd0;
			done     = 1'b0;
			n_bad    = 0;
		endfunction

		function void write_reg(input logic [1:0] idx, input logic [6:0] d);
			case (idx)
				CFG_COMMAND_INDEX:  cmd_idx = d[2:0];
				CFG_TARGET_ADDRESS: tgt_addr = d;
				CFG_READ_MODE:      rd_mode = d[0];
				default:            ;
			endcase
		endfunction

		// command frame byte; past the row it reads as zero
		function logic [7:0] cmd_byte(input logic [2:0] pos);
			logic [47:0] row;
			case (cmd_idx)
				3'd0:    row = 48'hAA_04_01_E6_01_E2;
				3'd1:    row = 48'hAA_04_02_E6_01_E1;
				3'd2:    row = 48'hAA_04_03_E6_01_E0;
				3'd3:    row = 48'hAA_04_04_E6_01_E7;
				3'd4:    row = 48'hAA_04_05_E6_01_E6;
				3'd5:    row = 48'hAA_04_06_E6_01_E5;
				3'd6:    row = 48'hAA_04_07_E6_01_E4;
				default: row = 48'hAA_04_08_E0_01_ED;
			endcase
			if (pos >= ROW_LEN)
				return 8'h00;
			return row[47 - 8 * pos -: 8];
		endfunction

		// next frame byte, count saturates at 7
		function logic [7:0] take_byte();
			logic [7:0] b;
			b = cmd_byte(n_sent);
			if (n_sent != 3'd7)
				n_sent = n_sent + 3'd1;
			return b;
		endfunction

		function res_t decode_event(input evt_t e);
			res_t r;
			logic keep;
			r    = '0;
			keep = 1'b0;
			if (e.command == CMD_BEGIN) begin
				n_sent      = 3'd0;
				n_recv      = 5'd0;
				done        = 1'b0;
				r.ctl_start = 1'b1;
			end else if (e.status_code == ST_START) begin
				r.tx_byte = {tgt_addr, 1'b0};
				r.tx_load = 1'b1;
			end else if (e.status_code == ST_SLA_W_ACK) begin
				r.tx_byte = take_byte();
				r.tx_load = 1'b1;
			end else if (e.status_code == ST_SLA_W_NACK) begin
				r.ctl_stop = 1'b1;
				done       = 1'b1;
			end else if (e.status_code == ST_DATA_ACK) begin
				if (n_sent < SEND_LEN_DEF) begin
					r.tx_byte = take_byte();
					r.tx_load = 1'b1;
				end else if (rd_mode) begin
					r.ctl_start = 1'b1;
				end else begin
					r.ctl_stop = 1'b1;
					done       = 1'b1;
				end
			end else if (!rd_mode) begin
				done = 1'b1;
			end else if (e.status_code == ST_RESTART) begin
				r.tx_byte = {tgt_addr, 1'b1};
				r.tx_load = 1'b1;
			end else if (e.status_code == ST_SLA_R_ACK) begin
				r.ctl_ack = 1'b1;
			end else if (e.status_code == ST_RX_ACK) begin
				if (n_recv < RECV_LEN_DEF) begin
					keep      = 1'b1;
					r.ctl_ack = 1'b1;
				end
			end else if (e.status_code == ST_RX_NACK) begin
				keep       = (n_recv < RECV_LEN_DEF);
				r.ctl_stop = 1'b1;
				done       = 1'b1;
			end else if (e.status_code == ST_DATA_NACK) begin
				r.ctl_stop = 1'b1;
				done       = 1'b1;
				n_recv     = 5'd0;
			end else begin
				r.ctl_stop = 1'b1;
				done       = 1'b1;
			end

			if (keep) begin
				r.rx_position = n_recv;
				r.rx_data     = e.bus_byte;
				if (cmd_idx < 3'd4 && n_recv >= SCRAMBLE_FIRST && n_recv <= SCRAMBLE_LAST)
					r.rx_data = r.rx_data ^ cmd_byte(3'(KEY_COLUMN));
				r.rx_valid = 1'b1;
				n_recv     = n_recv + 5'd1;
			end
			if (e.command == CMD_EVENT && rd_mode && e.status_code == ST_RX_NACK)
				n_recv = 5'd0;
			r.transfer_done = done;
			return r;
		endfunction

		function void note_event(input evt_t e);
			exp_q.push_back(decode_event(e));
		endfunction

		function string fmt(input res_t r);
			return $sformatf("tx=%h ld=%b sta=%b sto=%b ack=%b rx=%h rv=%b pos=%0d done=%b",
				r.tx_byte, r.tx_load, r.ctl_start, r.ctl_stop, r.ctl_ack,
				r.rx_data, r.rx_valid, r.rx_position, r.transfer_done);
		endfunction

		function void check_result(input res_t got);
			res_t want;
			logic bad;
			if (exp_q.size() == 0) begin
				n_bad++;
				if (n_bad <= 10)
					$display("%0t: result with nothing pending: %s", $time, fmt(got));
				return;
			end
			want = exp_q.pop_front();
			bad = (got.tx_byte !== want.tx_byte) || (got.tx_load !== want.tx_load)
				|| (got.ctl_start !== want.ctl_start) || (got.ctl_stop !== want.ctl_stop)
				|| (got.ctl_ack !== want.ctl_ack) || (got.rx_data !== want.rx_data)
				|| (got.rx_valid !== want.rx_valid) || (got.rx_position !== want.rx_position)
				|| (got.transfer_done !== want.transfer_done);
			if (bad) begin
				n_bad++;
				if (n_bad <= 10)
					$display("%0t: mismatch\n  exp %s\n  got %s", $time, fmt(want), fmt(got));
			end
		endfunction

		function int pending();
			return exp_q.size();
		endfunction

	endclass

endpackage

### tb/tb_top.sv
// Top of the I2C write/read sequencer bench: clock, reset, event driver,
// result sink with stalls, config writes. Depends on i2cmws_pkg and i2cmws_tb_pkg.
`timescale 1ns / 1ps

module tb_top;

	import i2cmws_pkg::*;
	import i2cmws_tb_pkg::*;

	localparam int N_PHASES    = 8;
	localparam int RAND_ITEMS  = 850;
	localparam int HOLD_CYCLES = 40;

	// codes the decoder has no branch for, plus the unused register slot
	localparam logic [7:0] ST_BOGUS_LO = 8'h00;
	localparam logic [7:0] ST_BOGUS_HI = 8'hFF;
	localparam logic [1:0] CFG_SPARE   = 2'd3;

	logic       clk;
	logic       arst_n;
	logic       evt_valid;
	logic       evt_ready;
	evt_t       evt;
	logic       res_valid;
	logic       res_ready;
	res_t       res;
	logic       cfg_we;
	logic [1:0] cfg_index;
	logic [6:0] cfg_data;

	seq_scoreboard sb;
	int n_items;
	bit no_idle;   // both sides run flat out
	bit hold_req;  // asks the sink for one long hold-off

	i2c_master_write_read_sequencer_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_ready (evt_ready),
		.evt       (evt),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop in case a transfer never completes
	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// Result sink. Sampled at the rising edge, so values seen are the ones
	// set up before the edge; every accepted transfer goes to the scoreboard.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && res_valid === 1'b1 && res_ready === 1'b1)
			sb.check_result(res);
	end

	// res_ready driver: random stalls, or one long hold-off on request.
	// The hold-off is counted here so the sender keeps pushing meanwhile.
	initial begin
		res_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				res_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else if (!no_idle && $urandom_range(0, 99) < 12) begin
				res_ready <= 1'b0;
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	function automatic bit chance(input int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	function automatic logic [7:0] rand8();
		return 8'($urandom_range(0, 255));
	endfunction

	// half the time a known code, else anything in the byte range
	function automatic logic [7:0] pick_status();
		if (chance(50))
			return rand8();
		case ($urandom_range(0, 8))
			0:       return ST_START;
			1:       return ST_RESTART;
			2:       return ST_SLA_W_ACK;
			3:       return ST_SLA_W_NACK;
			4:       return ST_DATA_ACK;
			5:       return ST_DATA_NACK;
			6:       return ST_SLA_R_ACK;
			7:       return ST_RX_ACK;
			default: return ST_RX_NACK;
		endcase
	endfunction

	// Offer one event; called and returns at a falling edge. Valid stays up
	// across back-to-back items unless an idle gap is drawn.
	task automatic push_item(input logic cmd, input logic [7:0] st, input logic [7:0] b);
		evt_t e;
		e.command     = cmd;
		e.status_code = st;
		e.bus_byte    = b;
		if (!no_idle && chance(12)) begin
			evt_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		evt_valid <= 1'b1;
		evt       <= e;
		do
			@(posedge clk);
		while (evt_ready !== 1'b1);
		sb.note_event(e);
		n_items++;
		@(negedge clk);
	endtask

	task automatic status(input logic [7:0] st, input logic [7:0] b);
		push_item(CMD_EVENT, st, b);
	endtask

	// sender pauses until every pending result is back
	task automatic wait_drained();
		evt_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (3) @(negedge clk);
	endtask

	// Write all three registers, with junk in the unused data bits; if asked,
	// the spare index gets a write that must be ignored.
	task automatic set_config(input logic [2:0] ci, input logic [6:0] ta, input logic rm,
		input bit with_spare);
		logic [1:0] idx [4];
		logic [6:0] dat [4];
		int n;
		idx[0] = CFG_COMMAND_INDEX;
		dat[0] = 7'($urandom_range(0, 127));
		dat[0][2:0] = ci;
		idx[1] = CFG_TARGET_ADDRESS;
		dat[1] = ta;
		idx[2] = CFG_READ_MODE;
		dat[2] = 7'($urandom_range(0, 127));
		dat[2][0] = rm;
		idx[3] = CFG_SPARE;
		dat[3] = 7'($urandom_range(0, 127));
		n = with_spare ? 4 : 3;
		for (int i = 0; i < n; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= dat[i];
			@(posedge clk);
			sb.write_reg(idx[i], dat[i]);
			@(negedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// One transaction as firmware would see it, with random payload bytes
	// and now and then a short frame, a NACK, a stray code or an overrun.
	task automatic run_frame();
		int n_tx;
		int n_rx;
		int tail;
		if (chance(10))
			push_item(1'($urandom_range(0, 1)), pick_status(), rand8());
		push_item(CMD_BEGIN, rand8(), rand8());
		status(ST_START, rand8());
		if (chance(5)) begin
			status(ST_SLA_W_NACK, rand8());
			return;
		end
		status(ST_SLA_W_ACK, rand8());
		n_tx = chance(10) ? $urandom_range(0, 9) : SEND_LEN_DEF;
		repeat (n_tx) status(ST_DATA_ACK, rand8());
		if (chance(5)) begin
			status(ST_DATA_NACK, rand8());
			return;
		end
		// write-only mode normally stops here; sometimes push read codes anyway
		if (!sb.rd_mode && !chance(20))
			return;
		status(ST_RESTART, rand8());
		status(ST_SLA_R_ACK, rand8());
		// occasionally run past the receive buffer
		n_rx = chance(15) ? $urandom_range(RECV_LEN_DEF - 1, RECV_LEN_DEF + 4)
			: $urandom_range(0, RECV_LEN_DEF - 2);
		repeat (n_rx) status(ST_RX_ACK, rand8());
		tail = $urandom_range(0, 9);
		if (tail < 7)
			status(ST_RX_NACK, rand8());
		else if (tail < 9)
			status(ST_DATA_NACK, rand8());
		else
			status(pick_status(), rand8());
		if (chance(10))
			status(pick_status(), rand8());
	endtask

	initial begin
		logic [2:0] ci;
		logic [6:0] ta;
		logic       rm;
		int         phase_end;

		sb        = new();
		n_items   = 0;
		no_idle   = 1'b0;
		hold_req  = 1'b0;
		arst_n    = 1'b0;
		evt_valid = 1'b0;
		evt       = '0;
		cfg_we    = 1'b0;
		cfg_index = CFG_COMMAND_INDEX;
		cfg_data  = 7'd0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed pass on reset config (index 0, address 0, read mode):
		// full write phase ending in repeated START, scrambled and plain
		// response bytes, event after done, unknown codes, and the send
		// count running past the row into saturation.
		push_item(CMD_BEGIN, 8'hFF, 8'hFF);
		status(ST_START, 8'h00);
		status(ST_SLA_W_ACK, 8'hFF);
		repeat (SEND_LEN_DEF + 1) status(ST_DATA_ACK, rand8());
		status(ST_RESTART, 8'h00);
		status(ST_SLA_R_ACK, 8'h00);
		status(ST_RX_ACK, 8'hFF);
		status(ST_RX_ACK, 8'h00);
		status(ST_RX_ACK, 8'hE6);
		status(ST_RX_NACK, 8'h5A);
		status(ST_RX_ACK, 8'h3C);
		status(ST_BOGUS_LO, rand8());
		status(ST_BOGUS_HI, rand8());
		push_item(CMD_BEGIN, 8'h00, 8'h00);
		repeat (8) status(ST_SLA_W_ACK, rand8());
		status(ST_DATA_ACK, rand8());

		// Random phases, each on its own register setting. Extremes first,
		// then random settings. Phase 1 runs with no idling; phase 2 adds
		// a long sink hold-off so the block backs up and drops evt_ready.
		for (int p = 0; p < N_PHASES; p++) begin
			wait_drained();
			case (p)
				0:       begin ci = 3'd7; ta = 7'd127; rm = 1'b0; end
				1:       begin ci = 3'd0; ta = 7'd0;   rm = 1'b1; end
				2:       begin ci = 3'd3; ta = 7'd127; rm = 1'b1; end
				3:       begin ci = 3'd4; ta = 7'd0;   rm = 1'b1; end
				4:       begin ci = 3'd7; ta = 7'd0;   rm = 1'b1; end
				5:       begin ci = 3'd0; ta = 7'd127; rm = 1'b0; end
				default: begin
					ci = 3'($urandom_range(0, 7));
					ta = 7'($urandom_range(0, 127));
					rm = 1'($urandom_range(0, 1));
				end
			endcase
			set_config(ci, ta, rm, p == 3);
			no_idle = (p == 1) || (p == 2);
			if (p == 2)
				hold_req = 1'b1;
			phase_end = n_items + RAND_ITEMS / N_PHASES;
			while (n_items < phase_end)
				run_frame();
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (sb.n_bad == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
